// ----- rtl/smbp_pkg.sv -----
package smbp_pkg;

  localparam int POOL_DEPTH_DEF = 16;
  localparam int DIM_W          = 14;
  localparam int STATUS_W       = 3;

  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_EXACT    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RESIZED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FRESH    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd5;

  // request from the port side to the sequencer
  typedef struct packed {
    logic start;
    logic kind;
    logic backend;
  } smbp_cmd_t;

  // sequencer state seen by the port side
  typedef struct packed {
    logic                idle;
    logic                valid;
    logic [STATUS_W-1:0] status;
  } smbp_stat_t;

endpackage

// ----- rtl/smbp_ram.sv -----
module smbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/smbp_ctrl.sv -----
module smbp_ctrl
  import smbp_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int ID_W       = $clog2(POOL_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  smbp_cmd_t        cmd,
  input  logic [DIM_W-1:0] cmd_width,
  input  logic [DIM_W-1:0] cmd_height,
  input  logic [ID_W-1:0]  cmd_id,
  input  logic             res_take,
  output smbp_stat_t       stat,
  output logic [ID_W-1:0]  res_id
);

  localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int SZ_W  = 2 * DIM_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SIZE  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_LAST  = 3'd4;
  localparam logic [2:0] S_PUT   = 3'd5;

  localparam logic [ID_W-1:0] DEPTH_C = ID_W'(POOL_DEPTH);
  localparam logic [ID_W-1:0] ONE_C   = ID_W'(1);

  logic [2:0]          state, state_next;
  logic                kind_q;
  logic [DIM_W-1:0]    width_q, height_q;
  logic [ID_W-1:0]     id_q;
  logic [ID_W-1:0]     idx, idx_next;
  logic [ID_W-1:0]     cur_id, cur_id_next;
  logic [ID_W-1:0]     issued, issued_next;
  logic [ID_W-1:0]     fcount, fcount_next;
  logic [ID_W-1:0]     res_q, res_q_next;
  logic [STATUS_W-1:0] res_st, res_st_next;

  logic             f_we;
  logic [IDX_W-1:0] f_waddr, f_raddr;
  logic [ID_W-1:0]  f_wdata, f_rdata;
  logic             s_we;
  logic [IDX_W-1:0] s_waddr, s_raddr;
  logic [SZ_W-1:0]  s_wdata, s_rdata;

  logic [ID_W:0]   idx_p1, idx_p2;
  logic [ID_W-1:0] fcount_m1, rdata_m1, issued_p1;

  assign idx_p1    = {1'b0, idx} + (ID_W + 1)'(1);
  assign idx_p2    = {1'b0, idx} + (ID_W + 1)'(2);
  assign fcount_m1 = fcount - ONE_C;
  assign rdata_m1  = f_rdata - ONE_C;
  assign issued_p1 = issued + ONE_C;

  smbp_ram #(.WIDTH(ID_W), .DEPTH(POOL_DEPTH)) u_free_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  smbp_ram #(.WIDTH(SZ_W), .DEPTH(POOL_DEPTH)) u_size_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    cur_id_next = cur_id;
    issued_next = issued;
    fcount_next = fcount;
    res_q_next  = res_q;
    res_st_next = res_st;
    f_we        = 1'b0;
    f_waddr     = fcount[IDX_W-1:0];
    f_wdata     = id_q;
    f_raddr     = idx[IDX_W-1:0];
    s_we        = 1'b0;
    s_waddr     = issued[IDX_W-1:0];
    s_wdata     = {width_q, height_q};
    s_raddr     = rdata_m1[IDX_W-1:0];

    case (state)
      S_IDLE: begin
        if (cmd.start) begin
          idx_next   = '0;
          f_raddr    = '0;
          res_q_next = '0;
          state_next = S_PUT;
          if (cmd.kind == KIND_ACQUIRE) begin
            if (cmd_width == '0 || cmd_height == '0 || !cmd.backend) begin
              res_st_next = ST_REFUSED;
            end else if (fcount != '0) begin
              state_next = S_SCAN;
            end else if (issued < DEPTH_C) begin
              s_we        = 1'b1;
              s_wdata     = {cmd_width, cmd_height};
              issued_next = issued_p1;
              res_q_next  = issued_p1;
              res_st_next = ST_FRESH;
            end else begin
              res_st_next = ST_REFUSED;
            end
          end else begin
            if (cmd_id == '0 || cmd_id > issued) begin
              res_st_next = ST_IGNORED;
            end else if (fcount != '0) begin
              state_next = S_SCAN;
            end else begin
              // empty free list: append directly
              f_we        = 1'b1;
              f_wdata     = cmd_id;
              fcount_next = fcount + ONE_C;
              res_st_next = ST_RELEASED;
            end
          end
        end
      end
      S_SCAN: begin
        if (kind_q == KIND_ACQUIRE) begin
          cur_id_next = f_rdata;
          state_next  = S_SIZE;
        end else if (f_rdata == id_q) begin
          res_st_next = ST_IGNORED;
          state_next  = S_PUT;
        end else if (idx_p1 < {1'b0, fcount}) begin
          idx_next = idx_p1[ID_W-1:0];
          f_raddr  = idx_p1[IDX_W-1:0];
        end else if (fcount >= DEPTH_C) begin
          res_st_next = ST_IGNORED;
          state_next  = S_PUT;
        end else begin
          f_we        = 1'b1;
          fcount_next = fcount + ONE_C;
          res_st_next = ST_RELEASED;
          state_next  = S_PUT;
        end
      end
      S_SIZE: begin
        if (s_rdata == {width_q, height_q}) begin
          if (idx_p1 < {1'b0, fcount}) begin
            f_raddr    = idx_p1[IDX_W-1:0];
            state_next = S_SHIFT;
          end else begin
            fcount_next = fcount_m1;
            res_q_next  = cur_id;
            res_st_next = ST_EXACT;
            state_next  = S_PUT;
          end
        end else if (idx_p1 < {1'b0, fcount}) begin
          idx_next   = idx_p1[ID_W-1:0];
          f_raddr    = idx_p1[IDX_W-1:0];
          state_next = S_SCAN;
        end else begin
          // no exact fit: take the newest free id
          f_raddr    = fcount_m1[IDX_W-1:0];
          state_next = S_LAST;
        end
      end
      S_SHIFT: begin
        // close the gap: entry idx takes entry idx+1
        f_we     = 1'b1;
        f_waddr  = idx[IDX_W-1:0];
        f_wdata  = f_rdata;
        idx_next = idx_p1[ID_W-1:0];
        if (idx_p2 < {1'b0, fcount}) begin
          f_raddr = idx_p2[IDX_W-1:0];
        end else begin
          fcount_next = fcount_m1;
          res_q_next  = cur_id;
          res_st_next = ST_EXACT;
          state_next  = S_PUT;
        end
      end
      S_LAST: begin
        s_we        = 1'b1;
        s_waddr     = rdata_m1[IDX_W-1:0];
        fcount_next = fcount_m1;
        res_q_next  = f_rdata;
        res_st_next = ST_RESIZED;
        state_next  = S_PUT;
      end
      S_PUT: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= '0;
      fcount <= '0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
      fcount <= fcount_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd.start) begin
      kind_q   <= cmd.kind;
      width_q  <= cmd_width;
      height_q <= cmd_height;
      id_q     <= cmd_id;
    end
    idx    <= idx_next;
    cur_id <= cur_id_next;
    res_q  <= res_q_next;
    res_st <= res_st_next;
  end

  assign stat.idle   = (state == S_IDLE);
  assign stat.valid  = (state == S_PUT);
  assign stat.status = res_st;
  assign res_id      = res_q;

endmodule

// ----- rtl/size_matched_buffer_pool.sv -----
// Pool of sized buffers, ids 1 to POOL_DEPTH.
// s_* takes one request per item: tuser is the kind (0 acquire, 1 release),
// tdata carries width, height and buffer_id. m_* returns one item per
// request: tdata is the granted id, tuser the status code.
// cfg_* writes backend_ready; write it only while the pool is idle.
// s_tready is high only while the sequencer is idle, so one request is in
// work at a time. Refused requests, fresh ids and a release onto an empty
// free list go from idle straight to the result state, then into the output
// register. A request that walks the free list reads, for each entry looked
// at, the free-list entry and then (in an acquire) the size of that id; a
// release only reads the free-list entry. When an exact match is taken out,
// the entries behind it move down one by one; with no exact fit the newest
// free id is resized. Both lists sit in single-port-read RAMs.
// The result sits in an output register, so a new request can be taken
// while m_tready is low; the next result waits in the sequencer until that
// register frees up.
// rst clears the id counter, the free list and the output, and sets
// backend_ready to one.
module size_matched_buffer_pool
  import smbp_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int ID_W       = $clog2(POOL_DEPTH + 1),
  parameter int IN_DW      = ((2 * DIM_W + ID_W + 7) / 8) * 8,
  parameter int OUT_DW     = ((ID_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_DW-1:0]    s_tdata,   // width, height, buffer_id
  input  logic                s_tuser,   // kind
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_DW-1:0]   m_tdata,   // granted_id
  output logic [STATUS_W-1:0] m_tuser,   // status
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  logic                backend;
  smbp_cmd_t           cmd;
  smbp_stat_t          stat;
  logic [ID_W-1:0]     res_id;
  logic                res_take;
  logic [ID_W-1:0]     out_id;
  logic [STATUS_W-1:0] out_st;

  assign cfg_ready = 1'b1;
  assign s_tready  = stat.idle;
  assign res_take  = !m_tvalid || m_tready;

  assign cmd.start   = s_tvalid && s_tready;
  assign cmd.kind    = s_tuser;
  assign cmd.backend = backend;

  smbp_ctrl #(.POOL_DEPTH(POOL_DEPTH), .ID_W(ID_W)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cmd_width  (s_tdata[DIM_W-1:0]),
    .cmd_height (s_tdata[2*DIM_W-1:DIM_W]),
    .cmd_id     (s_tdata[2*DIM_W+ID_W-1:2*DIM_W]),
    .res_take   (res_take),
    .stat       (stat),
    .res_id     (res_id)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      backend  <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        backend <= cfg_data;
      end
      if (stat.valid && res_take) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.valid && res_take) begin
      out_id <= res_id;
      out_st <= stat.status;
    end
  end

  assign m_tdata = OUT_DW'(out_id);
  assign m_tuser = out_st;

endmodule

// ----- rtl/smbp_chk.sv -----
module smbp_chk
  import smbp_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int ID_W       = $clog2(POOL_DEPTH + 1),
  parameter int OUT_DW     = ((ID_W + 7) / 8) * 8
) (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OUT_DW-1:0]   m_tdata,
  input logic [STATUS_W-1:0] m_tuser
);

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_no_id_on_fail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_REFUSED || m_tuser == ST_RELEASED ||
                 m_tuser == ST_IGNORED) |-> m_tdata == '0)
    else $error("id given with a status that grants none");

  a_id_on_grant: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_EXACT || m_tuser == ST_RESIZED ||
                 m_tuser == ST_FRESH) |-> m_tdata != '0 &&
                 m_tdata <= OUT_DW'(POOL_DEPTH))
    else $error("grant without a valid id");

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind size_matched_buffer_pool smbp_chk #(
  .POOL_DEPTH (POOL_DEPTH),
  .ID_W       (ID_W),
  .OUT_DW     (OUT_DW)
) u_smbp_chk (.*);
